/* sv/pcrd_pkg.sv */
// ============================================================================
// pcrd_pkg
// Shared types, constants and helper functions of the packed cel row
// run-length decoder.
// ============================================================================
package pcrd_pkg;

   // Format limits.
   localparam int MAX_ROW_PIXELS = 2048;
   localparam int MAX_ROWS       = 2048;
   localparam int MAX_RESULTS    = 32;
   localparam int QUEUE_DEPTH    = 2;
   localparam int OUT_DEPTH      = 2;

   // Register indexes of the configuration port.
   localparam logic [1:0] CSR_PIXEL_BITS = 2'd0;
   localparam logic [1:0] CSR_ROW_WIDTH  = 2'd1;
   localparam logic [1:0] CSR_ROW_COUNT  = 2'd2;

   // Register reset values.
   localparam logic [4:0]  PIXEL_BITS_RESET = 5'd8;
   localparam logic [11:0] ROW_WIDTH_RESET  = 12'd320;
   localparam logic [11:0] ROW_COUNT_RESET  = 12'd240;

   // Packet type codes.
   localparam logic [1:0] TY_EOL     = 2'd0;
   localparam logic [1:0] TY_LITERAL = 2'd1;
   localparam logic [1:0] TY_TRANSP  = 2'd2;
   localparam logic [1:0] TY_REPEAT  = 2'd3;

   // Effective configuration seen by the decoder.
   typedef struct packed {
      logic [4:0]  pixel_bits;
      logic [11:0] width;
      logic [11:0] count;
   } cfg_type;

   // One input word tagged with its place in the image.
   typedef struct packed {
      logic [19:0] word_index;
      logic        image_start;
      logic [31:0] data_word;
   } word_type;

   // One decoded run.
   typedef struct packed {
      logic        last_of_word;
      logic        row_end;
      logic [10:0] row_number;
      logic        is_transparent;
      logic [6:0]  run_length;
      logic [15:0] pixel_value;
   } res_type;

   // Unsupported depths decode as 8 bits per pixel.
   function automatic logic [4:0] eff_pixel_bits(input logic [4:0] bits);
      logic [4:0] r;
      unique case (bits)
         5'd1, 5'd2, 5'd4, 5'd6, 5'd8, 5'd16: r = bits;
         default: r = 5'd8;
      endcase
      return r;
   endfunction

   // Width is clamped to one pixel at least and to MAX_ROW_PIXELS.
   function automatic logic [11:0] eff_row_width(input logic [11:0] w);
      logic [11:0] r;
      r = (w == 12'd0) ? 12'd1 : w;
      if (r > 12'(MAX_ROW_PIXELS)) begin
         r = 12'(MAX_ROW_PIXELS);
      end
      return r;
   endfunction

   function automatic logic [11:0] eff_row_count(input logic [11:0] c);
      return (c > 12'(MAX_ROWS)) ? 12'(MAX_ROWS) : c;
   endfunction

endpackage

/* sv/pcrd_fifo.sv */
// ============================================================================
// pcrd_fifo
// Small register queue with valid/ready on both sides.
// ============================================================================
module pcrd_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [WIDTH-1:0] in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [WIDTH-1:0] out_data
);
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             push, pop;

   assign in_ready  = (count_ff != CW'(DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_data  = mem_ff[rd_ptr_ff];
   assign push      = in_valid & in_ready;
   assign pop       = out_valid & out_ready;

   // Pointer and fill level update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= in_data;
      end
   end

endmodule

/* sv/pcrd_front.sv */
// ============================================================================
// pcrd_front
// Input side: accepts words and tags each with its word index in the image.
// ============================================================================
module pcrd_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [31:0]        req_tdata,
   input  logic               req_tuser,
   output logic               push_valid,
   input  logic               push_ready,
   output pcrd_pkg::word_type push_data
);
   import pcrd_pkg::*;

   logic [19:0] word_index_ff, word_index_in;
   logic [19:0] idx;
   logic        accept;

   assign req_tready = push_ready;
   assign push_valid = req_tvalid;
   assign accept     = req_tvalid & push_ready;

   // An image start restarts the word count at zero.
   assign idx = req_tuser ? 20'd0 : word_index_ff;

   always_comb begin
      push_data.data_word   = req_tdata;
      push_data.image_start = req_tuser;
      push_data.word_index  = idx;
      word_index_in         = accept ? idx + 20'd1 : word_index_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_index_ff <= '0;
      end else begin
         word_index_ff <= word_index_in;
      end
   end

endmodule

/* sv/pcrd_back.sv */
// ============================================================================
// pcrd_back
// Decode engine: walks the bit stream one word at a time, one packet or one
// pixel code per cycle unless stalled, and hands runs to the output queue.
// ============================================================================
module pcrd_back (
   input  logic               clock,
   input  logic               reset,
   input  pcrd_pkg::cfg_type  cfg,
   input  logic               in_valid,
   output logic               in_ready,
   input  pcrd_pkg::word_type in_data,
   output logic               out_valid,
   input  logic               out_ready,
   output pcrd_pkg::res_type  out_data
);
   import pcrd_pkg::*;

   typedef enum logic [2:0] {
      B_IDLE, B_CHECK, B_HEAD, B_PARSE, B_FLUSH
   } state_type;

   typedef enum logic [2:0] {
      PH_HEADER, PH_PACKET, PH_REPEAT, PH_LITERAL, PH_SKIP, PH_DONE
   } phase_type;

   state_type   state_ff, state_in;
   phase_type   phase_ff, phase_in;
   logic [31:0] word_ff, word_in;
   logic [19:0] idx_ff, idx_in;
   logic [47:0] buf_ff, buf_in;
   logic [5:0]  held_ff, held_in;
   logic [6:0]  lit_ff, lit_in;
   logic [11:0] pix_ff, pix_in;
   logic [10:0] row_ff, row_in;
   logic [19:0] nrw_ff, nrw_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        pend_v_ff, pend_v_in;
   res_type     pend_ff, pend_in;

   logic [47:0] align;
   logic [15:0] top16;
   logic [15:0] code;
   logic [1:0]  ptype;
   logic [6:0]  pcount;
   logic        bpp_ok;
   logic [5:0]  held_less_bpp;
   logic        row_last;
   logic        hdr8;
   logic [6:0]  held_sum;

   logic        run_go;
   logic [15:0] run_val;
   logic [6:0]  run_req;
   logic        run_tr;
   logic [11:0] left;
   logic [6:0]  run_len;
   logic [11:0] pix_sum;
   logic        fill;

   logic        emit_go;
   res_type     emit_res;
   logic        end_row;
   logic        end_to_header;
   logic        room;
   logic        stall;

   // Keep only the n lowest bits of the bit buffer.
   function automatic logic [47:0] keep_low(input logic [47:0] v, input logic [5:0] n);
      return v & ~({48{1'b1}} << n);
   endfunction

   // Left-justify the held bits so the next fields sit at the top.
   assign align         = buf_ff << (6'd48 - held_ff);
   assign top16         = align[47:32];
   assign code          = top16 >> (5'd16 - cfg.pixel_bits);
   assign ptype         = align[47:46];
   assign pcount        = {1'b0, align[45:40]} + 7'd1;
   assign bpp_ok        = (held_ff >= {1'b0, cfg.pixel_bits});
   assign held_less_bpp = held_ff - {1'b0, cfg.pixel_bits};
   assign hdr8          = (cfg.pixel_bits <= 5'd6);
   assign held_sum      = {1'b0, held_ff} + 7'd32;

   // The image is finished after the last configured row or row 2047.
   assign row_last = (({1'b0, row_ff} + 12'd1) >= cfg.count) || (row_ff == 11'h7FF);

   // Clip a run to the pixels left in the row.
   assign left    = (cfg.width > pix_ff) ? cfg.width - pix_ff : 12'd0;
   assign run_len = ({5'b0, run_req} > left) ? left[6:0] : run_req;
   assign pix_sum = pix_ff + {5'b0, run_len};
   assign fill    = (pix_sum >= cfg.width);

   // Results past the per-word limit are dropped.
   assign room      = (cnt_ff < 6'(MAX_RESULTS));
   assign stall     = emit_go && room && pend_v_ff && !out_ready;
   assign out_valid = (emit_go && room && pend_v_ff) || (state_ff == B_FLUSH && pend_v_ff);
   assign in_ready  = (state_ff == B_IDLE);

   always_comb begin
      out_data              = pend_ff;
      out_data.last_of_word = (state_ff == B_FLUSH);
   end

   // Next-state logic of the decode sequencer.
   always_comb begin
      state_in      = state_ff;
      phase_in      = phase_ff;
      word_in       = word_ff;
      idx_in        = idx_ff;
      buf_in        = buf_ff;
      held_in       = held_ff;
      lit_in        = lit_ff;
      pix_in        = pix_ff;
      row_in        = row_ff;
      nrw_in        = nrw_ff;
      cnt_in        = cnt_ff;
      pend_v_in     = pend_v_ff;
      pend_in       = pend_ff;
      run_go        = 1'b0;
      run_val       = '0;
      run_req       = '0;
      run_tr        = 1'b0;
      emit_go       = 1'b0;
      emit_res      = '0;
      end_row       = 1'b0;
      end_to_header = 1'b0;

      unique case (state_ff)
         B_IDLE: begin
            if (in_valid) begin
               word_in  = in_data.data_word;
               idx_in   = in_data.word_index;
               cnt_in   = '0;
               state_in = B_CHECK;
               if (in_data.image_start) begin
                  buf_in   = '0;
                  held_in  = '0;
                  phase_in = PH_HEADER;
                  lit_in   = '0;
                  pix_in   = '0;
                  row_in   = '0;
                  nrw_in   = '0;
               end
            end
         end

         // A word at the next row start ends any row still in progress.
         B_CHECK: begin
            state_in = B_HEAD;
            if (phase_ff != PH_DONE && phase_ff != PH_HEADER && idx_ff == nrw_ff) begin
               if (phase_ff == PH_SKIP) begin
                  phase_in = PH_HEADER;
               end else begin
                  emit_go             = 1'b1;
                  emit_res.row_number = row_ff;
                  emit_res.row_end    = 1'b1;
                  end_row             = 1'b1;
                  end_to_header       = 1'b1;
               end
            end
         end

         // Row header or append to the bit buffer.
         B_HEAD: begin
            if (phase_ff == PH_HEADER) begin
               if ({1'b0, row_ff} >= cfg.count) begin
                  phase_in = PH_DONE;
                  state_in = B_FLUSH;
               end else begin
                  if (hdr8) begin
                     buf_in  = {24'b0, word_ff[23:0]};
                     held_in = 6'd24;
                     nrw_in  = idx_ff + {12'b0, word_ff[31:24]} + 20'd2;
                  end else begin
                     buf_in  = {32'b0, word_ff[15:0]};
                     held_in = 6'd16;
                     nrw_in  = idx_ff + {4'b0, word_ff[31:16]} + 20'd2;
                  end
                  pix_in   = '0;
                  lit_in   = '0;
                  phase_in = PH_PACKET;
                  state_in = B_PARSE;
               end
            end else if (phase_ff == PH_PACKET || phase_ff == PH_REPEAT ||
                         phase_ff == PH_LITERAL) begin
               buf_in   = {buf_ff[15:0], word_ff};
               held_in  = (held_sum > 7'd48) ? 6'd48 : held_sum[5:0];
               state_in = B_PARSE;
            end else begin
               state_in = B_FLUSH;
            end
         end

         // One packet header or one pixel code per cycle, unless stalled.
         B_PARSE: begin
            unique case (phase_ff)
               PH_PACKET: begin
                  if (held_ff < 6'd2) begin
                     state_in = B_FLUSH;
                  end else if (ptype == TY_EOL) begin
                     emit_go             = 1'b1;
                     emit_res.row_number = row_ff;
                     emit_res.row_end    = 1'b1;
                     end_row             = 1'b1;
                     state_in            = B_FLUSH;
                  end else if (held_ff < 6'd8) begin
                     state_in = B_FLUSH;
                  end else begin
                     held_in = held_ff - 6'd8;
                     buf_in  = keep_low(buf_ff, held_ff - 6'd8);
                     unique case (ptype)
                        TY_LITERAL: begin
                           lit_in   = pcount;
                           phase_in = PH_LITERAL;
                        end
                        TY_TRANSP: begin
                           run_go  = 1'b1;
                           run_req = pcount;
                           run_tr  = 1'b1;
                        end
                        TY_REPEAT: begin
                           lit_in   = pcount;
                           phase_in = PH_REPEAT;
                        end
                        default: begin
                           state_in = B_FLUSH;
                        end
                     endcase
                  end
               end
               PH_REPEAT: begin
                  if (!bpp_ok) begin
                     state_in = B_FLUSH;
                  end else begin
                     held_in  = held_less_bpp;
                     buf_in   = keep_low(buf_ff, held_less_bpp);
                     lit_in   = '0;
                     phase_in = PH_PACKET;
                     run_go   = 1'b1;
                     run_val  = code;
                     run_req  = lit_ff;
                  end
               end
               PH_LITERAL: begin
                  if (!bpp_ok) begin
                     state_in = B_FLUSH;
                  end else begin
                     held_in  = held_less_bpp;
                     buf_in   = keep_low(buf_ff, held_less_bpp);
                     lit_in   = (lit_ff != 7'd0) ? lit_ff - 7'd1 : 7'd0;
                     phase_in = (lit_ff > 7'd1) ? PH_LITERAL : PH_PACKET;
                     run_go   = 1'b1;
                     run_val  = code;
                     run_req  = 7'd1;
                  end
               end
               default: begin
                  state_in = B_FLUSH;
               end
            endcase
         end

         // Hand over the held result marked as the word's last.
         B_FLUSH: begin
            if (!pend_v_ff) begin
               state_in = B_IDLE;
            end else if (out_ready) begin
               pend_v_in = 1'b0;
               state_in  = B_IDLE;
            end
         end

         default: begin
            state_in = B_IDLE;
         end
      endcase

      // A run advances the row and may fill it.
      if (run_go) begin
         pix_in                  = pix_sum;
         emit_go                 = 1'b1;
         emit_res.pixel_value    = run_val;
         emit_res.run_length     = run_len;
         emit_res.is_transparent = run_tr;
         emit_res.row_number     = row_ff;
         emit_res.row_end        = fill;
         end_row                 = fill;
      end

      // Row end clears the bit stream and moves to the next row or ends the image.
      if (end_row) begin
         pix_in  = '0;
         lit_in  = '0;
         buf_in  = '0;
         held_in = '0;
         if (row_last) begin
            phase_in = PH_DONE;
         end else begin
            row_in   = row_ff + 11'd1;
            phase_in = end_to_header ? PH_HEADER : PH_SKIP;
         end
      end

      // The newest result waits so the last one of a word can be marked.
      if (emit_go && room) begin
         pend_in   = emit_res;
         pend_v_in = 1'b1;
         cnt_in    = cnt_ff + 6'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= B_IDLE;
         phase_ff  <= PH_HEADER;
         buf_ff    <= '0;
         held_ff   <= '0;
         lit_ff    <= '0;
         pix_ff    <= '0;
         row_ff    <= '0;
         nrw_ff    <= '0;
         cnt_ff    <= '0;
         pend_v_ff <= 1'b0;
      end else if (!stall) begin
         state_ff  <= state_in;
         phase_ff  <= phase_in;
         buf_ff    <= buf_in;
         held_ff   <= held_in;
         lit_ff    <= lit_in;
         pix_ff    <= pix_in;
         row_ff    <= row_in;
         nrw_ff    <= nrw_in;
         cnt_ff    <= cnt_in;
         pend_v_ff <= pend_v_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (!stall) begin
         word_ff <= word_in;
         idx_ff  <= idx_in;
         pend_ff <= pend_in;
      end
   end

endmodule

/* sv/packed_cel_row_rle_decoder.sv */
// ============================================================================
// packed_cel_row_rle_decoder
// Turns packed cel image rows into runs of pixel code, length and
// transparency.
// ============================================================================
// Usage:
//   The req channel carries one 32-bit word of packed data per transaction,
//   most significant bit first; req_tuser high marks the first word of an
//   image. The rsp channel carries one run per transaction; rsp_tlast marks
//   the last run of a row.
//   Configuration is written through csr_wr_en, csr_index and csr_wdata while
//   the block is idle; a write takes effect at the next clock edge.
// Decode steps:
//   A word sits in a two-entry input queue; the decode engine then takes it,
//   checks the row boundary, loads the header or the bit buffer, parses one
//   packet header or pixel code per step, reaches a step that finds too few
//   bits or a closed row (not reached after an end-of-line packet), and closes
//   the word. A skipped or ignored word goes from the header step straight
//   to closing the word.
// Reset and stall:
//   Reset clears the decoder to the start of an image and restores the
//   register defaults. A stalled rsp side fills the two-entry output queue,
//   then holds the decode engine; the input queue keeps taking words until
//   it is full.
// ============================================================================
module packed_cel_row_rle_decoder (
   input  logic        clock,
   input  logic        reset,
   // Input words.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] data_word
   input  logic        req_tuser,   // [0] image_start
   // Output runs.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [15:0] pixel_value, [22:16] run_length,
                                    // [33:23] row_number, [39:34] zero
   output logic        rsp_tlast,   // row_end
   output logic [1:0]  rsp_tuser,   // [0] is_transparent, [1] last_of_word
   // Configuration writes.
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [11:0] csr_wdata
);
   import pcrd_pkg::*;

   logic [4:0]  pixel_bits_ff;
   logic [11:0] row_width_ff;
   logic [11:0] row_count_ff;
   cfg_type     cfg;

   logic        q_in_valid, q_in_ready;
   word_type    q_in_data;
   logic        q_out_valid, q_out_ready;
   word_type    q_out_data;
   logic        r_in_valid, r_in_ready;
   res_type     r_in_data;
   res_type     r_out_data;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         pixel_bits_ff <= PIXEL_BITS_RESET;
         row_width_ff  <= ROW_WIDTH_RESET;
         row_count_ff  <= ROW_COUNT_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_PIXEL_BITS: pixel_bits_ff <= csr_wdata[4:0];
            CSR_ROW_WIDTH:  row_width_ff  <= csr_wdata;
            CSR_ROW_COUNT:  row_count_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Effective settings after clamping.
   always_comb begin
      cfg.pixel_bits = eff_pixel_bits(pixel_bits_ff);
      cfg.width      = eff_row_width(row_width_ff);
      cfg.count      = eff_row_count(row_count_ff);
   end

   pcrd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .push_valid (q_in_valid),
      .push_ready (q_in_ready),
      .push_data  (q_in_data)
   );

   pcrd_fifo #(
      .WIDTH ($bits(word_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_word_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (q_in_valid),
      .in_ready  (q_in_ready),
      .in_data   (q_in_data),
      .out_valid (q_out_valid),
      .out_ready (q_out_ready),
      .out_data  (q_out_data)
   );

   pcrd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (q_out_valid),
      .in_ready  (q_out_ready),
      .in_data   (q_out_data),
      .out_valid (r_in_valid),
      .out_ready (r_in_ready),
      .out_data  (r_in_data)
   );

   pcrd_fifo #(
      .WIDTH ($bits(res_type)),
      .DEPTH (OUT_DEPTH)
   ) u_out_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (r_in_valid),
      .in_ready  (r_in_ready),
      .in_data   (r_in_data),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (r_out_data)
   );

   // Result packing.
   assign rsp_tdata = {6'b0, r_out_data.row_number, r_out_data.run_length,
                       r_out_data.pixel_value};
   assign rsp_tlast = r_out_data.row_end;
   assign rsp_tuser = {r_out_data.last_of_word, r_out_data.is_transparent};

endmodule
